### design/bsb_pkg.sv
// Shared types, constants and helper functions for the BCD to scaled binary unit.
package bsb_pkg;

  localparam int unsigned MAX_DIGITS = 8;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned LANE_IDX_W = $clog2(MAX_DIGITS);
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CNT_W      = 4;

  // Largest legal decimal digit.
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  // floor(x / 10) == (x * DIV10_RECIP) >> DIV10_SHIFT for every 32-bit x.
  localparam logic [DATA_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int unsigned       DIV10_SHIFT = 35;

  localparam logic [DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIGIT_COUNT    = 2'd0,
    REG_POINT_POSITION = 2'd1,
    REG_SCALE_MULT     = 2'd2
  } bsb_reg_e;

  // Weight sequencer states.
  typedef enum logic [1:0] {
    SEQ_TOP,
    SEQ_WALK,
    SEQ_READY
  } bsb_seq_e;

  // Status from the weight sequencer to the datapath.
  typedef struct packed {
    logic                  ready;
    logic                  cfg_bad;
    logic [MAX_DIGITS-1:0] used;
  } bsb_ctrl_t;

  // Registered result of one lane.
  typedef struct packed {
    logic [DATA_W-1:0] prod;
    logic              bad;
  } bsb_lane_t;

  // Truncated division by ten through a reciprocal multiply.
  function automatic logic [DATA_W-1:0] div10(input logic [DATA_W-1:0] x);
    logic [2*DATA_W-1:0] p;
    p = {{DATA_W{1'b0}}, x} * {{DATA_W{1'b0}}, DIV10_RECIP};
    return DATA_W'(p[2*DATA_W-1:DIV10_SHIFT]);
  endfunction

  // Powers of ten up to 10^7.
  function automatic logic [DATA_W-1:0] pow10(input logic [LANE_IDX_W-1:0] e);
    logic [DATA_W-1:0] r;
    case (e)
      3'd0:    r = 32'd1;
      3'd1:    r = 32'd10;
      3'd2:    r = 32'd100;
      3'd3:    r = 32'd1000;
      3'd4:    r = 32'd10000;
      3'd5:    r = 32'd100000;
      3'd6:    r = 32'd1000000;
      default: r = 32'd10000000;
    endcase
    return r;
  endfunction

endpackage

### design/bsb_if.sv
// Valid/ready channel interfaces for the input words and the results.
interface bsb_in_if;
  import bsb_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] bcd_word;

  modport source (output valid, output bcd_word, input ready);
  modport sink (input valid, input bcd_word, output ready);
endinterface

interface bsb_out_if;
  import bsb_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] scaled_value;
  logic              format_error;

  modport source (output valid, output scaled_value, output format_error, input ready);
  modport sink (input valid, input scaled_value, input format_error, output ready);
endinterface

### design/bsb_weight_seq.sv
// Configuration registers and the sequencer that derives the per-lane digit weights.
module bsb_weight_seq (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         cfg_we_i,
  input  logic [bsb_pkg::CFG_IDX_W-1:0]                cfg_idx_i,
  input  logic [bsb_pkg::DATA_W-1:0]                   cfg_wdata_i,
  output logic [bsb_pkg::MAX_DIGITS-1:0][bsb_pkg::DATA_W-1:0] weight_o,
  output bsb_pkg::bsb_ctrl_t                           ctrl_o
);
  import bsb_pkg::*;

  logic [CNT_W-1:0]      digit_count_q;
  logic [CNT_W-1:0]      point_pos_q;
  logic [DATA_W-1:0]     scale_mult_q;
  bsb_seq_e              state_q, state_d;
  logic [LANE_IDX_W-1:0] walk_q;
  logic [DATA_W-1:0]     cur_q;
  logic [MAX_DIGITS-1:0][DATA_W-1:0] lane_w_q;

  logic                  cfg_bad;
  logic [LANE_IDX_W-1:0] last_walk;
  logic [LANE_IDX_W-1:0] lane_idx;
  logic [DATA_W-1:0]     top_w;
  logic [DATA_W-1:0]     top_prod;
  logic                  seq_ready;
  logic                  walk_en;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_count_q <= 4'd8;
      point_pos_q   <= 4'd8;
      scale_mult_q  <= 32'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DIGIT_COUNT:    digit_count_q <= cfg_wdata_i[CNT_W-1:0];
        REG_POINT_POSITION: point_pos_q   <= cfg_wdata_i[CNT_W-1:0];
        REG_SCALE_MULT:     scale_mult_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A format is unusable when the digit count or the point is out of range.
  assign cfg_bad = (digit_count_q == '0) || (digit_count_q > CNT_W'(MAX_DIGITS)) ||
                   (point_pos_q > digit_count_q);

  assign last_walk = LANE_IDX_W'(digit_count_q - CNT_W'(1));
  assign lane_idx  = last_walk - walk_q;

  // Weight of the top used digit.
  assign top_prod = DATA_W'(scale_mult_q * pow10(LANE_IDX_W'(point_pos_q - CNT_W'(1))));
  assign top_w    = (point_pos_q == '0) ? div10(scale_mult_q) : top_prod;

  // Next state: a configuration write restarts the weight derivation.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEQ_TOP:   state_d = cfg_bad ? SEQ_READY : SEQ_WALK;
      SEQ_WALK:  state_d = (walk_q == last_walk) ? SEQ_READY : SEQ_WALK;
      SEQ_READY: state_d = SEQ_READY;
      default:   state_d = SEQ_TOP;
    endcase
    if (cfg_we_i) begin
      state_d = SEQ_TOP;
    end
  end

  // Sequencer outputs.
  always_comb begin
    seq_ready = 1'b0;
    walk_en   = 1'b0;
    unique case (state_q)
      SEQ_TOP:   ;
      SEQ_WALK:  walk_en = 1'b1;
      SEQ_READY: seq_ready = 1'b1;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_TOP;
      walk_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == SEQ_TOP) begin
        walk_q <= '0;
      end else if (walk_en) begin
        walk_q <= walk_q + LANE_IDX_W'(1);
      end
    end
  end

  // Walk down from the top digit, one division by ten per cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == SEQ_TOP) begin
      cur_q <= top_w;
    end else if (walk_en) begin
      lane_w_q[lane_idx] <= cur_q;
      cur_q              <= div10(cur_q);
    end
  end

  assign weight_o = lane_w_q;

  // Status to the datapath; lanes above the digit count take no part.
  always_comb begin
    ctrl_o.ready   = seq_ready;
    ctrl_o.cfg_bad = cfg_bad;
    for (int p = 0; p < MAX_DIGITS; p++) begin
      ctrl_o.used[p] = (CNT_W'(p) < digit_count_q);
    end
  end

endmodule

### design/bsb_lane.sv
// One digit lane: weights its nibble and checks that it is a decimal digit.
module bsb_lane (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic                          used_i,
  input  logic [bsb_pkg::DIGIT_W-1:0]   nibble_i,
  input  logic [bsb_pkg::DATA_W-1:0]    weight_i,
  output bsb_pkg::bsb_lane_t            res_o
);
  import bsb_pkg::*;

  bsb_lane_t res_q, res_d;

  // Product modulo 2^32; unused lanes contribute nothing.
  always_comb begin
    res_d.prod = DATA_W'({{(DATA_W-DIGIT_W){1'b0}}, nibble_i} * weight_i);
    if (!used_i) begin
      res_d.prod = '0;
    end
    res_d.bad = used_i && (nibble_i > DIGIT_MAX);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

### design/bsb_merge.sv
// Merge stage: sums the lane products, folds in errors and holds the result register.
module bsb_merge (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        en_i,
  input  logic                                        valid_i,
  input  logic                                        cfg_bad_i,
  input  bsb_pkg::bsb_lane_t [bsb_pkg::MAX_DIGITS-1:0] lane_i,
  bsb_out_if.source                                   res_o
);
  import bsb_pkg::*;

  logic                          valid_q;
  logic [DATA_W-1:0]             value_q;
  logic                          error_q;
  logic [MAX_DIGITS-1:0][DATA_W-1:0] level;
  logic [DATA_W-1:0]             sum;
  logic                          any_bad;
  logic [DATA_W-1:0]             value_d;
  logic                          error_d;

  // Adder tree over the lanes, all sums modulo 2^32.
  always_comb begin
    for (int p = 0; p < MAX_DIGITS; p++) begin
      level[p] = lane_i[p].prod;
    end
    for (int s = 1; s < MAX_DIGITS; s = s * 2) begin
      for (int p = 0; p + s < MAX_DIGITS; p = p + 2 * s) begin
        level[p] = level[p] + level[p+s];
      end
    end
    sum = level[0];
  end

  // Any error forces the all-ones value.
  always_comb begin
    any_bad = cfg_bad_i;
    for (int p = 0; p < MAX_DIGITS; p++) begin
      any_bad = any_bad | lane_i[p].bad;
    end
    error_d = any_bad;
    value_d = any_bad ? ALL_ONES : sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q <= value_d;
      error_q <= error_d;
    end
  end

  assign res_o.valid        = valid_q;
  assign res_o.scaled_value = value_q;
  assign res_o.format_error = error_q;

endmodule

### design/bcd_to_scaled_binary_unit.sv
// Top level of the BCD to scaled binary unit: weight sequencer, digit lanes and merge stage.
//
// Converts one word of up to eight BCD digits per clock cycle into a scaled binary value;
// a result passes through the lane registers and then the merge result register after its
// word is accepted, and the pipeline moves only while the result register is empty or being
// taken. The digit weights are derived from the configuration by a sequencer that divides
// by ten through a reciprocal multiply, one digit per cycle: after reset and after every
// configuration write, input ready stays low while the weights are rebuilt, or only through
// the top-weight state when the digit count or the point is out of range.
module bcd_to_scaled_binary_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bsb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bsb_pkg::DATA_W-1:0]     cfg_wdata_i,
  bsb_in_if.sink                         bcd_i,
  bsb_out_if.source                      res_o
);
  import bsb_pkg::*;

  logic [MAX_DIGITS-1:0][DATA_W-1:0] weight;
  bsb_ctrl_t                         ctrl;
  bsb_lane_t [MAX_DIGITS-1:0]        lane_res;
  logic                              en;
  logic                              accept;
  logic                              s1_valid_q;

  // The pipeline advances unless a finished result is stalled.
  assign en        = !res_o.valid || res_o.ready;
  assign bcd_i.ready = ctrl.ready && !cfg_we_i && en;
  assign accept    = bcd_i.valid && bcd_i.ready;

  bsb_weight_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .weight_o    (weight),
    .ctrl_o      (ctrl)
  );

  // One lane per digit position.
  for (genvar p = 0; p < MAX_DIGITS; p++) begin : g_lane
    bsb_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (en),
      .used_i   (ctrl.used[p]),
      .nibble_i (bcd_i.bcd_word[p*DIGIT_W +: DIGIT_W]),
      .weight_i (weight[p]),
      .res_o    (lane_res[p])
    );
  end

  // Lane stage valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= accept;
    end
  end

  bsb_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (s1_valid_q),
    .cfg_bad_i (ctrl.cfg_bad),
    .lane_i    (lane_res),
    .res_o     (res_o)
  );

endmodule

### dv/testbench.sv
// Self-checking testbench for the BCD to scaled binary unit.
`timescale 1ns / 100ps

module testbench;
  import bsb_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_PHASES = 25;
  localparam int unsigned PHASE_WORDS   = 48;

  // The register port decodes four indexes but only three registers exist.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_IDX = 2'd3;

  // One expected conversion, with the word that caused it for messages.
  typedef struct {
    logic [DATA_W-1:0] bcd_word;
    logic [DATA_W-1:0] scaled_value;
    logic              format_error;
  } conversion_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DATA_W-1:0]    cfg_wdata_i;

  bsb_in_if  bcd_if ();
  bsb_out_if res_if ();

  bcd_to_scaled_binary_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .bcd_i       (bcd_if),
    .res_o       (res_if)
  );

  // Local copy of the configuration registers, at their reset values.
  logic [CNT_W-1:0]  cfg_digits = 4'd8;
  logic [CNT_W-1:0]  cfg_point  = 4'd8;
  logic [DATA_W-1:0] cfg_scale  = 32'd1;

  conversion_t pending_conversions[$];
  int unsigned mismatch_count     = 0;
  int unsigned cycle_count        = 0;
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned long_hold_req      = 0;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Computes the expected result of one word under the current configuration.
  function automatic conversion_t predict_conversion(input logic [DATA_W-1:0] word);
    conversion_t       r;
    logic [DATA_W-1:0] weight;
    logic [DATA_W-1:0] sum;
    logic              bad;
    bad = (cfg_digits == 0) || (cfg_digits > MAX_DIGITS) || (cfg_point > cfg_digits);
    if (!bad) begin
      for (int k = 0; k < cfg_digits; k++) begin
        if (word[4*k +: 4] > DIGIT_MAX) bad = 1'b1;
      end
    end
    r.bcd_word = word;
    if (bad) begin
      r.scaled_value = ALL_ONES;
      r.format_error = 1'b1;
      return r;
    end
    // Top digit weight; powers of ten applied one at a time wrap the same way.
    if (cfg_point == 0) begin
      weight = cfg_scale / 10;
    end else begin
      weight = cfg_scale;
      for (int k = 1; k < cfg_point; k++) weight = weight * 10;
    end
    sum = '0;
    for (int k = int'(cfg_digits) - 1; k >= 0; k--) begin
      sum = sum + weight * DATA_W'(word[4*k +: 4]);
      weight = weight / 10;
    end
    r.scaled_value = sum;
    r.format_error = 1'b0;
    return r;
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Selects how often each side idles.
  task automatic set_idling(input int unsigned mode);
    case (mode % 4)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 67; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 67; end
      default: begin sender_idle_pct = 37; receiver_stall_pct = 37; end
    endcase
  endtask

  // Offers one word and records its expected result once the transaction completes.
  task automatic send_word(input logic [DATA_W-1:0] word);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      bcd_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    bcd_if.valid    <= 1'b1;
    bcd_if.bcd_word <= word;
    do @(posedge clk_i); while (!bcd_if.ready);
    pending_conversions.push_back(predict_conversion(word));
    @(negedge clk_i);
  endtask

  // Stops offering words and waits until every expected result has arrived.
  task automatic wait_all_converted();
    bcd_if.valid <= 1'b0;
    while (pending_conversions.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Writes one register while the unit is idle and mirrors it locally.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    wait_all_converted();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_DIGIT_COUNT:    cfg_digits = value[CNT_W-1:0];
      REG_POINT_POSITION: cfg_point  = value[CNT_W-1:0];
      REG_SCALE_MULT:     cfg_scale  = value;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Count and point writes carry random upper bits that the unit must drop.
  task automatic write_config(input logic [CNT_W-1:0] digits, input logic [CNT_W-1:0] point,
                              input logic [DATA_W-1:0] scale);
    write_reg(REG_DIGIT_COUNT,
              {(DATA_W-CNT_W)'($urandom_range(0, 32'h0FFF_FFFF)), digits});
    write_reg(REG_POINT_POSITION,
              {(DATA_W-CNT_W)'($urandom_range(0, 32'h0FFF_FFFF)), point});
    write_reg(REG_SCALE_MULT, scale);
  endtask

  // Builds a word: mostly decimal in the used digits, sometimes with one bad digit.
  function automatic logic [DATA_W-1:0] make_word();
    logic [DATA_W-1:0] word;
    int unsigned       pick;
    int unsigned       pos;
    pick = $urandom_range(0, 99);
    if (pick >= 90) return $urandom();
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if (k < cfg_digits) word[4*k +: 4] = (pick < 5) ? DIGIT_MAX : 4'($urandom_range(0, 9));
      else word[4*k +: 4] = 4'($urandom_range(0, 15));
    end
    if (pick >= 80 && cfg_digits != 0) begin
      pos = $urandom_range(0, (cfg_digits > MAX_DIGITS) ? MAX_DIGITS - 1 : cfg_digits - 1);
      word[4*pos +: 4] = 4'($urandom_range(10, 15));
    end
    return word;
  endfunction

  // Default configuration: full eight-digit integers, scale one.
  task automatic test_reset_defaults();
    set_idling(0);
    send_word(32'h9999_9999);
    send_word(32'h0000_0000);
    send_word(32'h1234_5678);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_000A);
    send_word(32'hA000_0000);
  endtask

  // Extreme multipliers, a point of zero and a true all-ones result.
  task automatic test_digit_extremes();
    set_idling(3);
    write_config(4'd1, 4'd1, ALL_ONES);
    send_word(32'hFFFF_FFF1);
    send_word(32'hFFFF_FFF9);
    write_reg(REG_POINT_POSITION, 32'd0);
    send_word(32'h0000_0009);
    write_config(4'd8, 4'd0, ALL_ONES);
    send_word(32'h9999_9999);
    write_reg(REG_SCALE_MULT, 32'd0);
    send_word(32'h9999_9999);
  endtask

  // Illegal digit counts, a point beyond the digits, and ignored upper nibbles.
  task automatic test_config_errors();
    set_idling(0);
    write_config(4'd0, 4'd0, 32'd7);
    send_word(32'h0000_0000);
    write_reg(REG_DIGIT_COUNT, 32'hF);
    send_word(32'h1234_5678);
    write_reg(REG_DIGIT_COUNT, 32'd9);
    send_word(32'h0000_0001);
    write_config(4'd4, 4'd5, 32'd3);
    send_word(32'h0000_1234);
    write_reg(REG_POINT_POSITION, 32'd4);
    send_word(32'hABCD_1234);
  endtask

  // A write to the index past the register list must change nothing.
  task automatic test_unused_register();
    write_reg(REG_UNUSED_IDX, ALL_ONES);
    send_word(32'hFEDC_9876);
    send_word(32'h0000_0000);
  endtask

  // Random configurations, each followed by a phase of random words.
  task automatic test_random_conversions();
    logic [CNT_W-1:0]  digits;
    logic [CNT_W-1:0]  point;
    logic [DATA_W-1:0] scale;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 19))
        0:       digits = 4'd0;
        1:       digits = 4'($urandom_range(9, 15));
        2, 3:    digits = 4'd1;
        4, 5:    digits = 4'd8;
        default: digits = 4'($urandom_range(1, 8));
      endcase
      if ($urandom_range(0, 9) == 0) point = 4'($urandom_range(0, 15));
      else point = 4'($urandom_range(0, digits));
      case ($urandom_range(0, 7))
        0:       scale = 32'd0;
        1:       scale = 32'd1;
        2:       scale = ALL_ONES;
        3:       scale = $urandom();
        4:       scale = $urandom_range(0, 1000);
        default: scale = $urandom_range(1, 50000);
      endcase
      if (phase % 6 == 5) write_reg(REG_UNUSED_IDX, $urandom());
      write_config(digits, point, scale);
      set_idling(phase);
      for (int k = 0; k < PHASE_WORDS; k++) send_word(make_word());
    end
  endtask

  // The receiver holds off for a long stretch while words keep coming.
  task automatic test_backpressure_fill();
    write_config(4'd8, 4'd3, 32'd1000);
    set_idling(0);
    long_hold_req = 100;
    for (int k = 0; k < 40; k++) send_word(make_word());
  endtask

  // Short bursts, each followed by a pause until every result is back.
  task automatic test_drain_pause();
    int unsigned burst;
    set_idling(3);
    for (int round = 0; round < 4; round++) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst; k++) send_word(make_word());
      wait_all_converted();
    end
  endtask

  // Result ready, with a long hold-off when a test asks for one.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req != 0) begin
        hold_left = long_hold_req;
        long_hold_req = 0;
      end
      if (hold_left != 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
    end
  end

  // Compares every result transaction with the oldest expectation.
  initial begin
    conversion_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        if (pending_conversions.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h error %b",
                                    res_if.scaled_value, res_if.format_error));
        end else begin
          want = pending_conversions.pop_front();
          if (res_if.scaled_value !== want.scaled_value)
            report_mismatch($sformatf("word %h: scaled_value %h, expected %h",
                                      want.bcd_word, res_if.scaled_value, want.scaled_value));
          if (res_if.format_error !== want.format_error)
            report_mismatch($sformatf("word %h: format_error %b, expected %b",
                                      want.bcd_word, res_if.format_error, want.format_error));
        end
      end
    end
  end

  // Ends a run that hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL bcd_to_scaled_binary_unit");
    $finish;
  end

  // Main sequence.
  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_DIGIT_COUNT;
    cfg_wdata_i     = '0;
    bcd_if.valid    = 1'b0;
    bcd_if.bcd_word = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_digit_extremes();
    test_config_errors();
    test_unused_register();
    test_random_conversions();
    test_backpressure_fill();
    test_drain_pause();

    wait_all_converted();
    repeat (8) @(posedge clk_i);
    if (pending_conversions.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_conversions.size()));
    if (mismatch_count == 0) begin
      $display("PASS bcd_to_scaled_binary_unit");
    end else begin
      $display("FAIL bcd_to_scaled_binary_unit");
    end
    $finish;
  end

endmodule
